// ===== rtl/core/etre_pkg.sv =====
`timescale 1ns / 1ps
// etre_pkg: shared constants, payload types, state enums and run helpers
// for the escape-tag run-length encoder. No dependencies.
package etre_pkg;

  // block size and derived widths
  localparam int DEPTH       = 8192;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RUN_CAP     = 256;
  localparam int RUN_W       = $clog2(RUN_CAP + 1);
  localparam int MIN_ESC_RUN = 4;
  localparam int STOP_MARGIN = 133;
  localparam int STOP_LEVEL  = DEPTH - STOP_MARGIN;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } etre_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_last;
    logic       stream_last;
  } etre_out_t;

  // one run (or the tag byte) to be expanded into output bytes by the back end
  typedef struct packed {
    logic [7:0]       value;
    logic [7:0]       tag;
    logic [RUN_W-1:0] len;
    logic             escaped;
    logic             item_end;
    logic             stream_end;
  } etre_cmd_t;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_READY,
    PH_ENCODING,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CNT_WR,
    F_SCAN,
    F_TAGSEL,
    F_EVAL,
    F_PUSH
  } fst_t;

  // a run is escaped when long enough or when it repeats the tag itself
  function automatic logic run_escaped(input logic [7:0] held, input logic [RUN_W-1:0] run,
                                       input logic [7:0] tag);
    return (run >= RUN_W'(MIN_ESC_RUN)) || (held == tag);
  endfunction

  // number of stream bytes produced by flushing a run
  function automatic logic [1:0] flush_size(input logic [7:0] held,
                                            input logic [RUN_W-1:0] run,
                                            input logic [7:0] tag);
    return run_escaped(held, run, tag) ? 2'd3 : run[1:0];
  endfunction

  function automatic etre_cmd_t run_cmd(input logic [7:0] held, input logic [RUN_W-1:0] run,
                                        input logic [7:0] tag, input logic item_end,
                                        input logic stream_end);
    etre_cmd_t c;
    c.value      = held;
    c.tag        = tag;
    c.len        = run;
    c.escaped    = run_escaped(held, run, tag);
    c.item_end   = item_end;
    c.stream_end = stream_end;
    return c;
  endfunction

  // the tag byte goes out as a single literal byte
  function automatic etre_cmd_t tag_cmd(input logic [7:0] tag, input logic item_end);
    etre_cmd_t c;
    c.value      = tag;
    c.tag        = tag;
    c.len        = RUN_W'(1);
    c.escaped    = 1'b0;
    c.item_end   = item_end;
    c.stream_end = 1'b0;
    return c;
  endfunction

endpackage

// ===== rtl/core/etre_front.sv =====
`timescale 1ns / 1ps
// etre_front: accepts transactions, keeps the block store and value histogram,
// picks the tag and turns each encode step into run commands. Uses etre_pkg.
module etre_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  etre_pkg::etre_in_t item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output etre_pkg::etre_cmd_t cmd
);
  import etre_pkg::*;

  fst_t             state;
  fst_t             state_next;
  phase_t           phase;
  logic [CNT_W-1:0] load_index;
  logic [CNT_W-1:0] read_index;
  logic [CNT_W-1:0] emitted_count;
  logic [7:0]       escape_tag;
  logic [7:0]       held_byte;
  logic [RUN_W-1:0] run_count;

  // block store and histogram memories
  logic [7:0]        store [DEPTH];
  logic [7:0]        st_rdata;
  logic              st_re;
  logic              st_we;
  logic [ADDR_W-1:0] st_raddr;
  logic [ADDR_W-1:0] st_waddr;
  logic [CNT_W-1:0]  cnt_mem [256];
  logic [CNT_W-1:0]  cnt_rdata;
  logic              cnt_rvld;
  logic [255:0]      cnt_valid;
  logic [7:0]        cnt_raddr;
  logic [CNT_W-1:0]  cnt_val;
  logic [7:0]        ld_byte;

  // tag search
  logic [7:0]       scan_idx;
  logic [7:0]       scan_idx_d;
  logic             scan_dv;
  logic [CNT_W-1:0] min_cnt;
  logic [7:0]       tag_min;
  logic             take_new;
  logic [7:0]       cur_tag;

  // pending commands
  etre_cmd_t pend_a;
  etre_cmd_t pend_b;
  logic      pend_a_vld;
  logic      pend_b_vld;

  logic             accept;
  logic             restart;
  logic [CNT_W-1:0] ld_next;
  logic             ts_finish;
  logic             ev_close;
  logic [CNT_W-1:0] ev_emit;
  logic [7:0]       ev_held;
  logic [RUN_W-1:0] ev_run;
  logic [CNT_W-1:0] ev_ridx;
  logic             ev_finish;

  // handshake and block restart
  assign accept  = item_valid && item_ready;
  assign restart = accept && (item.op == OP_LOAD) && (phase != PH_LOADING);
  assign ld_next = restart ? CNT_W'(1) : load_index + CNT_W'(1);

  // histogram read data, unwritten entries count as zero
  assign cnt_val  = cnt_rvld ? cnt_rdata : '0;
  assign take_new = scan_dv && ((scan_idx_d == 8'd0) || (cnt_val < min_cnt));
  assign cur_tag  = take_new ? scan_idx_d : tag_min;

  // end check right after the tag step
  assign ts_finish = (1 >= DEPTH) || (1 >= STOP_LEVEL);

  // run tracking for one stored byte
  assign ev_close  = !((st_rdata == held_byte) && (run_count < RUN_W'(RUN_CAP)));
  assign ev_emit   = emitted_count +
                     (ev_close ? CNT_W'(flush_size(held_byte, run_count, escape_tag)) : '0);
  assign ev_held   = ev_close ? st_rdata : held_byte;
  assign ev_run    = ev_close ? RUN_W'(1) : run_count + RUN_W'(1);
  assign ev_ridx   = read_index + CNT_W'(1);
  assign ev_finish = (ev_ridx >= CNT_W'(DEPTH)) || (ev_emit >= CNT_W'(STOP_LEVEL));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (item.op == OP_LOAD) begin
            state_next = F_CNT_WR;
          end else if (phase == PH_READY) begin
            state_next = F_SCAN;
          end else if (phase == PH_ENCODING) begin
            state_next = F_EVAL;
          end
        end
      end
      F_CNT_WR: state_next = F_IDLE;
      F_SCAN: begin
        if (scan_idx == 8'hFF) begin
          state_next = F_TAGSEL;
        end
      end
      F_TAGSEL: state_next = F_PUSH;
      F_EVAL: begin
        if (ev_close || ev_finish) begin
          state_next = F_PUSH;
        end else begin
          state_next = F_IDLE;
        end
      end
      F_PUSH: begin
        if (cmd_ready && (!pend_a_vld || !pend_b_vld)) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    item_ready = (state == F_IDLE);
    cmd_valid  = (state == F_PUSH);
    cmd        = pend_a_vld ? pend_a : pend_b;
    st_we      = accept && (item.op == OP_LOAD);
    st_waddr   = restart ? '0 : load_index[ADDR_W-1:0];
    st_re      = accept && (item.op == OP_ENCODE);
    st_raddr   = (phase == PH_READY) ? '0 : read_index[ADDR_W-1:0];
    cnt_raddr  = (state == F_SCAN) ? scan_idx : item.data_byte;
  end

  // block store
  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= item.data_byte;
    end
    if (st_re) begin
      st_rdata <= store[st_raddr];
    end
  end

  // histogram counts, read on accept and written back in F_CNT_WR
  always_ff @(posedge clk) begin
    if (state == F_CNT_WR) begin
      cnt_mem[ld_byte] <= cnt_val + CNT_W'(1);
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
    cnt_rvld  <= !restart && cnt_valid[cnt_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      phase         <= PH_LOADING;
      load_index    <= '0;
      read_index    <= '0;
      emitted_count <= '0;
      escape_tag    <= '0;
      held_byte     <= '0;
      run_count     <= '0;
      cnt_valid     <= '0;
      scan_idx      <= '0;
      scan_dv       <= 1'b0;
      pend_a_vld    <= 1'b0;
      pend_b_vld    <= 1'b0;
    end else begin
      state   <= state_next;
      scan_dv <= (state == F_SCAN);
      unique case (state)
        F_IDLE: begin
          scan_idx <= '0;
          if (accept && (item.op == OP_LOAD)) begin
            if (restart) begin
              cnt_valid     <= '0;
              read_index    <= '0;
              emitted_count <= '0;
              run_count     <= '0;
            end
            load_index <= ld_next;
            phase      <= (ld_next >= CNT_W'(DEPTH)) ? PH_READY : PH_LOADING;
          end
        end
        F_CNT_WR: cnt_valid[ld_byte] <= 1'b1;
        F_SCAN: scan_idx <= scan_idx + 8'd1;
        F_TAGSEL: begin
          escape_tag    <= cur_tag;
          held_byte     <= st_rdata;
          read_index    <= CNT_W'(1);
          run_count     <= RUN_W'(1);
          emitted_count <= CNT_W'(1);
          phase         <= ts_finish ? PH_DONE : PH_ENCODING;
          pend_a_vld    <= 1'b1;
          pend_b_vld    <= ts_finish;
        end
        F_EVAL: begin
          read_index    <= ev_ridx;
          held_byte     <= ev_held;
          run_count     <= ev_run;
          emitted_count <= ev_emit;
          phase         <= ev_finish ? PH_DONE : PH_ENCODING;
          pend_a_vld    <= ev_close;
          pend_b_vld    <= ev_finish;
        end
        F_PUSH: begin
          if (cmd_ready) begin
            if (pend_a_vld) begin
              pend_a_vld <= 1'b0;
            end else begin
              pend_b_vld <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_d <= scan_idx;
    if (accept) begin
      ld_byte <= item.data_byte;
    end
    if (take_new) begin
      min_cnt <= cnt_val;
      tag_min <= scan_idx_d;
    end
    if (state == F_TAGSEL) begin
      pend_a <= tag_cmd(cur_tag, !ts_finish);
      pend_b <= run_cmd(st_rdata, RUN_W'(1), cur_tag, 1'b1, 1'b1);
    end else if (state == F_EVAL) begin
      pend_a <= run_cmd(held_byte, run_count, escape_tag, !ev_finish, 1'b0);
      pend_b <= run_cmd(ev_held, ev_run, escape_tag, 1'b1, 1'b1);
    end
  end

endmodule

// ===== rtl/core/etre_cmd_fifo.sv =====
`timescale 1ns / 1ps
// etre_cmd_fifo: small command queue that decouples the front end from the
// byte emitter. Uses etre_pkg.
module etre_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  etre_pkg::etre_cmd_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output etre_pkg::etre_cmd_t rd_data
);
  import etre_pkg::*;

  etre_cmd_t             slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  push;
  logic                  pop;

  // status and head entry
  assign wr_ready = (count != (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (CMDQ_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (CMDQ_PTR_W + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/etre_emit.sv =====
`timescale 1ns / 1ps
// etre_emit: expands run commands into stream bytes, one byte per cycle while
// the output is not stalled, behind a registered output stage. Uses etre_pkg.
module etre_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  etre_pkg::etre_cmd_t cmd,
  output logic                result_valid,
  input  logic                result_ready,
  output etre_pkg::etre_out_t result
);
  import etre_pkg::*;

  etre_cmd_t  cur;
  logic       cur_vld;
  logic [1:0] beat;
  logic [1:0] nbeats;
  logic       last_beat;
  logic       load_out;
  logic       fire;
  logic       pop;
  logic [7:0] beat_byte;

  // beat count: escaped runs take three bytes, literal runs one per repeat
  assign nbeats    = cur.escaped ? 2'd3 : cur.len[1:0];
  assign last_beat = (beat == nbeats - 2'd1);
  assign load_out  = !result_valid || result_ready;
  assign fire      = cur_vld && load_out;
  assign cmd_ready = !cur_vld || (fire && last_beat);
  assign pop       = cmd_valid && cmd_ready;

  // byte for the current beat
  always_comb begin
    if (!cur.escaped) begin
      beat_byte = cur.value;
    end else if (beat == 2'd0) begin
      beat_byte = cur.tag;
    end else if (beat == 2'd1) begin
      beat_byte = cur.value;
    end else begin
      beat_byte = cur.len[7:0] - 8'd1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld      <= 1'b0;
      beat         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= cur_vld;
      end
      if (pop) begin
        cur_vld <= 1'b1;
        beat    <= '0;
      end else if (fire) begin
        if (last_beat) begin
          cur_vld <= 1'b0;
          beat    <= '0;
        end else begin
          beat <= beat + 2'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (fire) begin
      result.out_byte    <= beat_byte;
      result.item_last   <= last_beat && cur.item_end;
      result.stream_last <= last_beat && cur.stream_end;
    end
  end

endmodule

// ===== rtl/core/escape_tag_rle_encoder_core.sv =====
`timescale 1ns / 1ps
// escape_tag_rle_encoder_core: top level of the escape-tag run-length encoder.
// Depends on etre_pkg, etre_front, etre_cmd_fifo and etre_emit.
//
//   channel  | signals                                 | transaction
//   ---------+-----------------------------------------+---------------------------------
//   item     | item_valid, item_ready, item            | op (load / encode), data_byte
//   result   | result_valid, result_ready, result      | out_byte, item_last, stream_last
//
// A load writes the block store and reads the histogram, then writes the histogram back.
// An encode step produces at most 2 run commands.
// The first encode step of a block scans all 256 histogram entries.
// The emitter sends one byte per cycle while the receiver takes them, from a 4-entry
// command queue, so either side may stall without holding up the other until the queue fills.
// Synchronous reset returns to the loading phase with an empty histogram.
module escape_tag_rle_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  etre_pkg::etre_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output etre_pkg::etre_out_t result
);
  import etre_pkg::*;

  etre_cmd_t fq_wr_data;
  logic      fq_wr_valid;
  logic      fq_wr_ready;
  etre_cmd_t fq_rd_data;
  logic      fq_rd_valid;
  logic      fq_rd_ready;

  // accept and classify
  etre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (fq_wr_valid),
    .cmd_ready  (fq_wr_ready),
    .cmd        (fq_wr_data)
  );

  // command queue
  etre_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_wr_valid),
    .wr_ready (fq_wr_ready),
    .wr_data  (fq_wr_data),
    .rd_valid (fq_rd_valid),
    .rd_ready (fq_rd_ready),
    .rd_data  (fq_rd_data)
  );

  // byte emitter
  etre_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (fq_rd_valid),
    .cmd_ready    (fq_rd_ready),
    .cmd          (fq_rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for escape_tag_rle_encoder_core, with its own
// encoder predictor and whole-block tests. Depends on etre_pkg and the core RTL.
module testbench;
  import etre_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_ready;
  etre_in_t  item         = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  etre_out_t result;

  escape_tag_rle_encoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  blk_mem [DEPTH];
  int unsigned hist [256];
  int unsigned n_loaded;
  int unsigned rd_idx;
  int unsigned n_emitted;
  int unsigned run_len;
  logic [7:0]  tag_val;
  logic [7:0]  run_byte;
  phase_t      enc_phase;

  etre_out_t   expected_stream_q [$];
  logic [7:0]  step_bytes [$];
  logic [7:0]  fill_q [$];

  // bookkeeping
  int   mismatch_count  = 0;
  int   items_accepted  = 0;
  int   results_checked = 0;
  int   streams_done    = 0;
  int   stall_cycles    = 0;
  logic tx_gaps_on      = 1'b1;
  logic rx_gaps_on      = 1'b1;
  logic rx_holding      = 1'b0;
  event rx_hold_ev;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // predictor: stream byte output
  task automatic emit_byte(input logic [7:0] v);
    step_bytes.push_back(v);
    n_emitted++;
  endtask

  // close the held run: escaped triple or literal copies
  task automatic close_run();
    if (run_len >= MIN_ESC_RUN || run_byte == tag_val) begin
      emit_byte(tag_val);
      emit_byte(run_byte);
      emit_byte(8'(run_len - 1));
    end else begin
      repeat (run_len) emit_byte(run_byte);
    end
  endtask

  // predictor: one accepted transaction in, expected stream bytes out
  task automatic predict_stream_bytes(input etre_in_t word);
    logic [7:0] nb;
    logic       done_now;
    int         k;
    step_bytes.delete();
    done_now = 1'b0;
    if (word.op == OP_LOAD) begin
      // a load outside the loading phase starts a fresh block
      if (enc_phase != PH_LOADING) begin
        foreach (hist[v]) hist[v] = 0;
        n_loaded  = 0;
        rd_idx    = 0;
        n_emitted = 0;
        run_len   = 0;
        enc_phase = PH_LOADING;
      end
      if (n_loaded < DEPTH) begin
        blk_mem[n_loaded] = word.data_byte;
        hist[word.data_byte]++;
        n_loaded++;
      end
      if (n_loaded >= DEPTH) enc_phase = PH_READY;
      return;
    end
    if (enc_phase == PH_READY) begin
      // least counted value wins, lowest value on ties
      tag_val = 8'd0;
      for (int v = 1; v < 256; v++)
        if (hist[v] < hist[tag_val]) tag_val = 8'(v);
      n_emitted = 0;
      emit_byte(tag_val);
      run_byte  = blk_mem[0];
      rd_idx    = 1;
      run_len   = 1;
      enc_phase = PH_ENCODING;
    end else if (enc_phase == PH_ENCODING) begin
      nb = blk_mem[rd_idx];
      rd_idx++;
      if (nb == run_byte && run_len < RUN_CAP) begin
        run_len++;
      end else begin
        close_run();
        run_byte = nb;
        run_len  = 1;
      end
    end else begin
      return;
    end
    // end of block or output budget reached: flush the open run
    if (rd_idx >= DEPTH || n_emitted >= STOP_LEVEL) begin
      close_run();
      enc_phase = PH_DONE;
      done_now  = 1'b1;
      streams_done++;
    end
    for (k = 0; k < step_bytes.size(); k++) begin
      etre_out_t r;
      r.out_byte    = step_bytes[k];
      r.item_last   = (k == step_bytes.size() - 1);
      r.stream_last = r.item_last && done_now;
      expected_stream_q.push_back(r);
    end
  endtask

  // send one transaction, optionally after a random gap
  task automatic issue_step(input logic op, input logic [7:0] value);
    etre_in_t word;
    word.op        = op;
    word.data_byte = value;
    if (tx_gaps_on && $urandom_range(99) < 28) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= word;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_accepted++;
    predict_stream_bytes(word);
  endtask

  // block building helpers
  task automatic add_run(input logic [7:0] v, input int n);
    repeat (n) if (fill_q.size() < DEPTH) fill_q.push_back(v);
  endtask

  task automatic load_fill(input int count);
    repeat (count) issue_step(OP_LOAD, fill_q.pop_front());
  endtask

  task automatic encode_steps(input int max_steps);
    int n;
    n = 0;
    while (enc_phase != PH_DONE && n < max_steps) begin
      issue_step(OP_ENCODE, 8'($urandom_range(255)));
      n++;
    end
  endtask

  // result checker and receiver ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_checked++;
        if (expected_stream_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", result.out_byte));
        end else begin
          etre_out_t exp_r;
          exp_r = expected_stream_q.pop_front();
          if (result.out_byte !== exp_r.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      result.out_byte, exp_r.out_byte));
          if (result.item_last !== exp_r.item_last)
            report_mismatch($sformatf("item_last %b, want %b",
                                      result.item_last, exp_r.item_last));
          if (result.stream_last !== exp_r.stream_last)
            report_mismatch($sformatf("stream_last %b, want %b",
                                      result.stream_last, exp_r.stream_last));
        end
      end
      result_ready <= !(rx_holding || (rx_gaps_on && $urandom_range(99) < 28));
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(rx_hold_ev);
      rx_holding <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // encode steps while still loading are dropped
  task automatic test_encode_before_load();
    issue_step(OP_ENCODE, 8'h00);
    issue_step(OP_ENCODE, 8'hff);
    issue_step(OP_ENCODE, 8'h5a);
  endtask

  // every value counted equally: tag is zero and zero shows up as data
  task automatic test_tied_counts();
    fill_q.delete();
    for (int i = 0; i < DEPTH / 2; i++) fill_q.push_back(8'(i));
    for (int v = 0; v < 256; v++) add_run(8'(v), (DEPTH / 2) / 256);
    load_fill(DEPTH);
    // stretch with no idling on either side
    tx_gaps_on <= 1'b0;
    rx_gaps_on <= 1'b0;
    encode_steps(DEPTH + 4);
    tx_gaps_on <= 1'b1;
    rx_gaps_on <= 1'b1;
    // encode after the stream is done is dropped
    issue_step(OP_ENCODE, 8'h00);
    issue_step(OP_ENCODE, 8'hff);
  endtask

  // mostly distinct bytes: stream stops at the output budget
  task automatic test_output_budget_stop();
    fill_q.delete();
    while (fill_q.size() < DEPTH) begin
      if ($urandom_range(99) < 90) add_run(8'($urandom_range(255)), 1);
      else add_run(8'($urandom_range(255)), $urandom_range(2, 3));
    end
    // first load restarts from the done phase
    load_fill(DEPTH);
    encode_steps(DEPTH + 4);
  endtask

  // run lengths around the escape threshold and the run cap, rare tag value
  task automatic test_run_lengths();
    int         pieces [$];
    int         special [$];
    int         rare;
    int         j;
    int         tmp;
    logic [7:0] v;
    fill_q.delete();
    rare    = $urandom_range(255);
    special = '{1, 2, 3, 4, 255, 256, 257, 512, 513, 1000};
    pieces  = '{(rare << 16) | 1, (rare << 16) | 2, (rare << 16) | 1};
    for (int x = 0; x < 256; x++)
      if (x != rare) pieces.push_back((x << 16) | 5);
    foreach (special[i])
      pieces.push_back((((rare + $urandom_range(1, 255)) % 256) << 16) | special[i]);
    for (int i = pieces.size() - 1; i > 0; i--) begin
      j         = $urandom_range(i);
      tmp       = pieces[i];
      pieces[i] = pieces[j];
      pieces[j] = tmp;
    end
    foreach (pieces[i]) add_run(8'(pieces[i] >> 16), pieces[i] & 16'hffff);
    while (fill_q.size() < DEPTH) begin
      v = 8'((rare + $urandom_range(1, 255)) % 256);
      add_run(v, ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 300));
    end
    load_fill(DEPTH);
    // hold the receiver off while encode steps keep coming
    issue_step(OP_ENCODE, 8'($urandom_range(255)));
    -> rx_hold_ev;
    encode_steps(DEPTH + 4);
  endtask

  // load on a full block abandons it before encoding starts
  task automatic test_restart_from_ready();
    fill_q.delete();
    while (fill_q.size() < 2 * DEPTH)
      repeat ($urandom_range(1, 6)) fill_q.push_back(8'($urandom_range(255)));
    load_fill(DEPTH);
    load_fill(DEPTH);
  endtask

  // load part way through a stream starts a new block
  task automatic test_restart_mid_stream();
    encode_steps($urandom_range(50, 400));
    issue_step(OP_LOAD, 8'hff);
    issue_step(OP_ENCODE, 8'h00);
    issue_step(OP_ENCODE, 8'hff);
    issue_step(OP_LOAD, 8'h00);
    issue_step(OP_LOAD, 8'($urandom_range(255)));
  endtask

  // main sequence
  initial begin
    foreach (hist[v]) hist[v] = 0;
    n_loaded  = 0;
    rd_idx    = 0;
    n_emitted = 0;
    run_len   = 0;
    tag_val   = 8'd0;
    run_byte  = 8'd0;
    enc_phase = PH_LOADING;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_before_load();
    test_tied_counts();
    test_output_budget_stop();
    test_run_lengths();
    test_restart_from_ready();
    test_restart_mid_stream();

    item_valid <= 1'b0;
    while (expected_stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d transactions in, %0d stream bytes checked, %0d streams finished",
             items_accepted, results_checked, streams_done);
    $display("tied and rare tags, run cap, budget stop, restarts and dropped steps exercised");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/etre_pkg.sv
rtl/core/etre_front.sv
rtl/core/etre_cmd_fifo.sv
rtl/core/etre_emit.sv
rtl/core/escape_tag_rle_encoder_core.sv
tb/testbench.sv
